// ----- hdl/rrs_pkg.sv -----
// ----------------------------------------------------------------------------
// rrs_pkg
// Shared types, constants and helpers of the round-robin scheduler.
// ----------------------------------------------------------------------------
package rrs_pkg;

  localparam int unsigned QueueDepthDefault = 16;

  typedef enum logic [2:0] {
    EV_START  = 3'd0,
    EV_RESUME = 3'd1,
    EV_STOP   = 3'd2,
    EV_FINISH = 3'd3,
    EV_REJECT = 3'd4
  } ev_kind_e;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] burst;
    logic [15:0] arrival;
    logic [15:0] remaining;
  } task_t;

  typedef struct packed {
    logic exec;
    logic disp;
  } rrs_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic need_disp;
  } rrs_stat_t;

  // now - arrival - (burst - remaining), clamped at 0
  function automatic logic [15:0] wait_of(task_t t, logic [15:0] now);
    logic signed [17:0] v;
    v = $signed({2'b00, now}) - $signed({2'b00, t.arrival})
      - $signed({2'b00, t.burst}) + $signed({2'b00, t.remaining});
    return v[17] ? 16'd0 : v[15:0];
  endfunction

  // now - arrival, clamped at 0
  function automatic logic [15:0] turnaround_of(task_t t, logic [15:0] now);
    logic signed [16:0] v;
    v = $signed({1'b0, now}) - $signed({1'b0, t.arrival});
    return v[16] ? 16'd0 : v[15:0];
  endfunction

endpackage

// ----- hdl/rrs_ctrl.sv -----
// ----------------------------------------------------------------------------
// rrs_ctrl
// Sequencer: runs an item, then a dispatch state when needed.
// ----------------------------------------------------------------------------
module rrs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rrs_pkg::rrs_stat_t stat_i,
  output rrs_pkg::rrs_cmd_t  cmd_o
);
  import rrs_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_DISP
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = !stat_i.slot_free;
        cmd_o.exec = in_valid_i && stat_i.slot_free;
        if (cmd_o.exec && stat_i.need_disp) begin
          state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        cmd_o.disp = stat_i.slot_free;
        if (stat_i.slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hdl/rrs_datapath.sv -----
// ----------------------------------------------------------------------------
// rrs_datapath
// Ready queue memory, running task, counters and the result register.
// ----------------------------------------------------------------------------
module rrs_datapath #(
  parameter int unsigned QUEUE_DEPTH = rrs_pkg::QueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rrs_pkg::rrs_cmd_t  cmd_i,
  output rrs_pkg::rrs_stat_t stat_o,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               op_i,
  input  logic [7:0]         task_id_i,
  input  logic [15:0]        burst_length_i,
  input  logic [15:0]        arrival_stamp_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         event_kind_o,
  output logic [7:0]         event_task_o,
  output logic [15:0]        event_time_o,
  output logic [15:0]        task_remaining_o,
  output logic [15:0]        task_waiting_o,
  output logic [15:0]        task_turnaround_o,
  output logic [15:0]        idle_total_o,
  output logic               last_event_o
);
  import rrs_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  task_t           mem [QUEUE_DEPTH];
  task_t           rd_q;

  logic [7:0]      time_slice_q;
  logic [15:0]     time_q, time_d;
  logic [15:0]     idle_q, idle_d;
  logic            run_valid_q, run_valid_d;
  task_t           run_q, run_d;
  logic [7:0]      slice_q, slice_d;
  logic [PW-1:0]   head_q, head_d;
  logic [PW-1:0]   tail_q, tail_d;
  logic [CW-1:0]   count_q, count_d;
  logic            requeue_q, requeue_d;

  logic            out_valid_q;
  ev_kind_e        ev_kind_q, ev_kind;
  task_t           ev_task_q, ev_task;
  logic [15:0]     ev_time_q;
  logic [15:0]     ev_wait_q, ev_wait;
  logic [15:0]     ev_ta_q, ev_ta;
  logic [15:0]     ev_idle_q;
  logic            ev_last_q, ev_last;
  logic            emit;

  logic            mem_we;
  task_t           mem_wdata;

  task_t           in_task;
  task_t           run_tick;
  task_t           disp_src;
  logic [15:0]     time_inc;
  logic [15:0]     rem_dec;
  logic [7:0]      limit;
  logic [7:0]      slice_inc;
  logic [7:0]      slice_tick;
  logic            expire;
  logic            finish;
  logic            full;
  logic            q_empty;
  logic            slot_free;

  function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign in_task   = '{id: task_id_i, burst: burst_length_i,
                       arrival: arrival_stamp_i, remaining: burst_length_i};
  assign full      = (count_q == CW'(QUEUE_DEPTH));
  assign q_empty   = (count_q == '0);
  assign time_inc  = time_q + 16'd1;
  assign rem_dec   = (run_q.remaining == 16'd0) ? 16'd0 : run_q.remaining - 16'd1;
  assign limit     = (time_slice_q == 8'd0) ? 8'd1 : time_slice_q;
  assign slice_inc = (slice_q == 8'hFF) ? slice_q : slice_q + 8'd1;
  assign finish    = (rem_dec == 16'd0);
  assign slice_tick = finish ? limit : slice_inc;
  assign expire    = run_valid_q && (slice_tick >= limit);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign disp_src  = q_empty ? run_q : rd_q;

  always_comb begin
    run_tick           = run_q;
    run_tick.remaining = rem_dec;
  end

  assign stat_o.slot_free = slot_free;
  assign stat_o.need_disp = !op_i && expire && (!finish || !q_empty);

  always_comb begin
    time_d      = time_q;
    idle_d      = idle_q;
    run_valid_d = run_valid_q;
    run_d       = run_q;
    slice_d     = slice_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    requeue_d   = requeue_q;
    emit        = 1'b0;
    ev_kind     = EV_STOP;
    ev_task     = run_q;
    ev_wait     = 16'd0;
    ev_ta       = 16'd0;
    ev_last     = 1'b1;
    mem_we      = 1'b0;
    mem_wdata   = run_q;

    if (cmd_i.exec) begin
      if (op_i) begin
        if (full) begin
          emit    = 1'b1;
          ev_kind = EV_REJECT;
          ev_task = in_task;
        end else if (run_valid_q) begin
          mem_we    = 1'b1;
          mem_wdata = in_task;
          tail_d    = ptr_inc(tail_q);
          count_d   = count_q + 1'b1;
        end else begin
          run_valid_d = 1'b1;
          run_d       = in_task;
          slice_d     = 8'd0;
          emit        = 1'b1;
          ev_kind     = EV_START;
          ev_task     = in_task;
          ev_wait     = wait_of(in_task, time_q);
        end
      end else begin
        time_d = time_inc;
        if (!run_valid_q) begin
          idle_d  = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;
          slice_d = time_slice_q;
        end else begin
          run_d   = run_tick;
          slice_d = slice_tick;
          if (expire) begin
            emit      = 1'b1;
            ev_kind   = finish ? EV_FINISH : EV_STOP;
            ev_task   = run_tick;
            ev_wait   = wait_of(run_tick, time_inc);
            ev_ta     = finish ? turnaround_of(run_tick, time_inc) : 16'd0;
            ev_last   = finish && q_empty;
            requeue_d = !finish;
            if (finish && q_empty) begin
              run_valid_d = 1'b0;
              slice_d     = time_slice_q;
            end
          end
        end
      end
    end else if (cmd_i.disp) begin
      if (!q_empty) begin
        head_d = ptr_inc(head_q);
        if (requeue_q) begin
          mem_we = 1'b1;
          tail_d = ptr_inc(tail_q);
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      run_valid_d = 1'b1;
      run_d       = disp_src;
      slice_d     = 8'd0;
      emit        = 1'b1;
      ev_kind     = (disp_src.remaining == disp_src.burst) ? EV_START : EV_RESUME;
      ev_task     = disp_src;
      ev_wait     = wait_of(disp_src, time_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_slice_q <= 8'd1;
      time_q       <= '0;
      idle_q       <= '0;
      run_valid_q  <= 1'b0;
      run_q        <= '0;
      slice_q      <= 8'd1;
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      requeue_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        time_slice_q <= cfg_wdata_i;
      end
      time_q      <= time_d;
      idle_q      <= idle_d;
      run_valid_q <= run_valid_d;
      run_q       <= run_d;
      slice_q     <= slice_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      requeue_q   <= requeue_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      ev_kind_q <= ev_kind;
      ev_task_q <= ev_task;
      ev_time_q <= time_d;
      ev_wait_q <= ev_wait;
      ev_ta_q   <= ev_ta;
      ev_idle_q <= idle_d;
      ev_last_q <= ev_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[tail_q] <= mem_wdata;
    end
    if (cmd_i.exec) begin
      rd_q <= mem[head_q];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign event_kind_o      = ev_kind_q;
  assign event_task_o      = ev_task_q.id;
  assign event_time_o      = ev_time_q;
  assign task_remaining_o  = ev_task_q.remaining;
  assign task_waiting_o    = ev_wait_q;
  assign task_turnaround_o = ev_ta_q;
  assign idle_total_o      = ev_idle_q;
  assign last_event_o      = ev_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("ready queue count beyond depth");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run_valid_q |-> q_empty)
    else $error("tasks queued with nothing running");

  a_ptr_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_empty |-> (head_q == tail_q))
    else $error("queue pointers disagree with count");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> slot_free)
    else $error("result register overwritten while stalled");

  a_disp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.disp && q_empty) |-> (requeue_q && run_valid_q))
    else $error("dispatch with no task to run");

endmodule

// ----- hdl/round_robin_scheduler.sv -----
// ----------------------------------------------------------------------------
// round_robin_scheduler
// Round-robin task scheduler with a fixed time slice.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o): one item is a tick (op_i = 0) or a
// task arrival (op_i = 1). Output channel (out_valid_o / out_stall_i): event
// items; last_event_o marks the final event caused by an input item.
// An item is taken when the result register is free; its first event shows on
// the output in the next cycle. A tick that ends a slice or a task and
// dispatches the next one then goes to a dispatch state for the dispatch event,
// whose queue entry comes from a registered read of the ready queue memory; no
// new item is taken until that dispatch event is issued.
// time_slice is written through cfg_we_i / cfg_wdata_i; the user must write it
// only while the block is idle, as the block does not enforce this; 0 acts as 1.
// Reset empties the queue, clears time and idle counters and sets the time
// slice to 1. While the receiver stalls, the pending event is held and no new
// item is taken.
// ----------------------------------------------------------------------------
module round_robin_scheduler #(
  parameter int unsigned QUEUE_DEPTH = rrs_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [7:0]  task_id_i,
  input  logic [15:0] burst_length_i,
  input  logic [15:0] arrival_stamp_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_kind_o,
  output logic [7:0]  event_task_o,
  output logic [15:0] event_time_o,
  output logic [15:0] task_remaining_o,
  output logic [15:0] task_waiting_o,
  output logic [15:0] task_turnaround_o,
  output logic [15:0] idle_total_o,
  output logic        last_event_o
);
  import rrs_pkg::*;

  rrs_cmd_t  cmd;
  rrs_stat_t stat;

  rrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rrs_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .op_i              (op_i),
    .task_id_i         (task_id_i),
    .burst_length_i    (burst_length_i),
    .arrival_stamp_i   (arrival_stamp_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .event_kind_o      (event_kind_o),
    .event_task_o      (event_task_o),
    .event_time_o      (event_time_o),
    .task_remaining_o  (task_remaining_o),
    .task_waiting_o    (task_waiting_o),
    .task_turnaround_o (task_turnaround_o),
    .idle_total_o      (idle_total_o),
    .last_event_o      (last_event_o)
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for round_robin_scheduler. A directed table covers the
// field extremes, slice expiry, zero-burst tasks, idle arrivals and the full
// ready queue. Random tick/arrival sequences then run under several time
// slices. Each item is also fed to a predictor of the scheduler, and every
// event is compared field by field against the oldest predicted event. Both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import rrs_pkg::*;

  localparam int unsigned DEPTH = QueueDepthDefault;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ARRIVE = 1'b1;

  typedef struct {
    ev_kind_e    kind;
    logic [7:0]  id;
    logic [15:0] stamp;
    logic [15:0] rem;
    logic [15:0] waiting;
    logic [15:0] turnaround;
    logic [15:0] idle;
    logic        last;
  } sched_ev_t;

  typedef struct {
    logic        op;
    logic [7:0]  id;
    logic [15:0] burst;
    logic [15:0] arr;
    bit          typed;
    ev_kind_e    x_kind;
    logic [7:0]  x_id;
    logic [15:0] x_rem;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        op = OP_TICK;
  logic [7:0]  task_id = 8'd0;
  logic [15:0] burst_length = 16'd0;
  logic [15:0] arrival_stamp = 16'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  event_kind;
  logic [7:0]  event_task;
  logic [15:0] event_time;
  logic [15:0] task_remaining;
  logic [15:0] task_waiting;
  logic [15:0] task_turnaround;
  logic [15:0] idle_total;
  logic        last_event;

  // predicted scheduler state
  task_t       rq [DEPTH];
  int unsigned q_head, q_tail, q_cnt;
  bit          run_v;
  task_t       run_t;
  int unsigned slice_cnt;
  logic [7:0]  slice_reg;
  logic [15:0] now_t;
  logic [15:0] idle_t;

  sched_ev_t   evs[$];
  sched_ev_t   pending_ev[$];
  dir_row_t    dir_tab[$];
  int unsigned mism = 0;
  int unsigned items_sent = 0;
  int unsigned stall_left = 0;
  int unsigned cycles = 0;
  bit          calm = 1'b0;

  round_robin_scheduler #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .op_i             (op),
    .task_id_i        (task_id),
    .burst_length_i   (burst_length),
    .arrival_stamp_i  (arrival_stamp),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .event_kind_o     (event_kind),
    .event_task_o     (event_task),
    .event_time_o     (event_time),
    .task_remaining_o (task_remaining),
    .task_waiting_o   (task_waiting),
    .task_turnaround_o(task_turnaround),
    .idle_total_o     (idle_total),
    .last_event_o     (last_event)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------- predictor ----------------

  function automatic logic [15:0] sat16(int v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  function automatic int unsigned slice_lim();
    return (slice_reg == 8'd0) ? 1 : int'(slice_reg);
  endfunction

  function automatic logic [15:0] waited(task_t t);
    return sat16(int'(now_t) - int'(t.arrival) - (int'(t.burst) - int'(t.remaining)));
  endfunction

  function automatic void note_event(ev_kind_e k, task_t t, logic [15:0] w,
                                     logic [15:0] ta);
    sched_ev_t e;
    e.kind = k;
    e.id = t.id;
    e.stamp = now_t;
    e.rem = t.remaining;
    e.waiting = w;
    e.turnaround = ta;
    e.idle = idle_t;
    e.last = 1'b0;
    evs.push_back(e);
  endfunction

  function automatic void push_ready(task_t t);
    rq[q_tail] = t;
    q_tail = (q_tail + 1) % DEPTH;
    q_cnt++;
  endfunction

  // take the queue head, else the preempted task; a preempted task goes in behind a taken head
  function automatic void dispatch(bit has_req, task_t req);
    task_t t;
    if (q_cnt == 0) begin
      if (!has_req) begin
        run_v = 1'b0;
        run_t = '0;
        slice_cnt = slice_reg;
        return;
      end
      t = req;
    end else begin
      t = rq[q_head];
      q_head = (q_head + 1) % DEPTH;
      q_cnt--;
      if (has_req) push_ready(req);
    end
    run_t = t;
    run_v = 1'b1;
    slice_cnt = 0;
    note_event((t.remaining == t.burst) ? EV_START : EV_RESUME, t, waited(t), 16'd0);
  endfunction

  function automatic void reset_sched();
    foreach (rq[i]) rq[i] = '0;
    q_head = 0;
    q_tail = 0;
    q_cnt = 0;
    run_v = 1'b0;
    run_t = '0;
    slice_reg = 8'd1;
    slice_cnt = 1;
    now_t = 16'd0;
    idle_t = 16'd0;
  endfunction

  function automatic void schedule_item(logic kind_op, logic [7:0] id, logic [15:0] burst,
                                        logic [15:0] arr);
    task_t t;
    evs.delete();
    if (kind_op == OP_ARRIVE) begin
      t.id = id;
      t.burst = burst;
      t.arrival = arr;
      t.remaining = burst;
      if (q_cnt >= DEPTH) begin
        note_event(EV_REJECT, t, 16'd0, 16'd0);
      end else begin
        push_ready(t);
        if (!run_v) dispatch(1'b0, '0);
      end
    end else begin
      now_t = now_t + 16'd1;
      if (run_v) begin
        if (run_t.remaining > 0) run_t.remaining--;
        if (run_t.remaining == 0) slice_cnt = slice_lim();
        else if (slice_cnt < 255) slice_cnt++;
        if (slice_cnt >= slice_lim()) begin
          t = run_t;
          if (t.remaining == 0) begin
            note_event(EV_FINISH, t, waited(t), sat16(int'(now_t) - int'(t.arrival)));
            dispatch(1'b0, '0);
          end else begin
            note_event(EV_STOP, t, waited(t), 16'd0);
            dispatch(1'b1, t);
          end
        end
      end else begin
        if (idle_t != 16'hFFFF) idle_t++;
        dispatch(1'b0, '0);
      end
    end
    if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
    foreach (evs[i]) pending_ev.push_back(evs[i]);
  endfunction

  // ---------------- result side ----------------

  function automatic void check_field(string name, logic [15:0] exp, logic [15:0] got);
    if (got !== exp) begin
      $error("%s: expected %0d, got %0d", name, exp, got);
      mism++;
    end
  endfunction

  always @(negedge clk) begin
    if (!calm && stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin : event_mon
    sched_ev_t e;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      stall_left = $urandom_range(0, 14);
      if (pending_ev.size() == 0) begin
        $error("unexpected event: kind %0d task %0d", event_kind, event_task);
        mism++;
      end else begin
        e = pending_ev.pop_front();
        check_field("event_kind", e.kind, event_kind);
        check_field("event_task", e.id, event_task);
        check_field("event_time", e.stamp, event_time);
        check_field("task_remaining", e.rem, task_remaining);
        check_field("task_waiting", e.waiting, task_waiting);
        check_field("task_turnaround", e.turnaround, task_turnaround);
        check_field("idle_total", e.idle, idle_total);
        check_field("last_event", e.last, last_event);
      end
    end
  end

  // ---------------- item side ----------------

  task automatic send_item(logic kind_op, logic [7:0] id, logic [15:0] burst,
                           logic [15:0] arr);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    op = kind_op;
    task_id = id;
    burst_length = burst;
    arrival_stamp = arr;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
    schedule_item(kind_op, id, burst, arr);
    @(negedge clk);
  endtask

  task automatic send_arrival();
    logic [15:0] b;
    logic [15:0] a;
    case ($urandom_range(0, 39))
      0:       b = 16'd0;
      1, 2:    b = 16'($urandom_range(13, 400));
      3, 4, 5: b = 16'($urandom_range(13, 60));
      default: b = 16'($urandom_range(1, 12));
    endcase
    a = ($urandom_range(0, 4) == 0) ? 16'($urandom) : now_t - 16'($urandom_range(0, 6));
    send_item(OP_ARRIVE, 8'($urandom), b, a);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 8'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (pending_ev.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_slice(logic [7:0] v);
    settle();
    cfg_we = 1'b1;
    cfg_wdata = v;
    slice_reg = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic run_phase(int unsigned n);
    int unsigned goal;
    int unsigned k;
    goal = items_sent + n;
    while (items_sent < goal) begin
      calm = ($urandom_range(0, 5) == 0);
      k = $urandom_range(0, 19);
      if (k == 0) begin
        // overrun the ready queue
        repeat (DEPTH + 3) send_arrival();
      end else if (k < 3) begin
        repeat ($urandom_range(1, 6))
          send_item($urandom_range(0, 1) ? OP_ARRIVE : OP_TICK, 8'($urandom),
                    16'($urandom_range(0, 40)), 16'($urandom));
      end else begin
        repeat ($urandom_range(1, 3)) send_arrival();
        repeat ($urandom_range(4, 30)) send_tick();
      end
    end
    calm = 1'b0;
  endtask

  function automatic void add_row(logic o, logic [7:0] id, logic [15:0] burst,
                                  logic [15:0] arr, bit typed, ev_kind_e k,
                                  logic [7:0] xid, logic [15:0] xrem);
    dir_row_t r;
    r.op = o;
    r.id = id;
    r.burst = burst;
    r.arr = arr;
    r.typed = typed;
    r.x_kind = k;
    r.x_id = xid;
    r.x_rem = xrem;
    dir_tab.push_back(r);
  endfunction

  logic [7:0] slice_plan [10] = '{8'd255, 8'd0, 8'd1, 8'd3, 8'd200, 8'd2, 8'd6, 8'd128,
                                  8'd1, 8'd17};

  initial begin
    dir_row_t row;
    reset_sched();
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // time slice is 1 after reset
    add_row(OP_TICK,   8'h00, 16'd0,     16'd0,     0, EV_START,  8'h00, 16'd0);
    add_row(OP_ARRIVE, 8'h00, 16'd1,     16'd0,     1, EV_START,  8'h00, 16'd1);
    add_row(OP_TICK,   8'h00, 16'd0,     16'd0,     1, EV_FINISH, 8'h00, 16'd0);
    add_row(OP_ARRIVE, 8'h81, 16'd300,   16'd2,     1, EV_START,  8'h81, 16'd300);
    add_row(OP_ARRIVE, 8'h7E, 16'd0,     16'd2,     0, EV_START,  8'h00, 16'd0);
    add_row(OP_TICK,   8'h00, 16'd0,     16'd0,     1, EV_STOP,   8'h81, 16'd299);
    add_row(OP_TICK,   8'h00, 16'd0,     16'd0,     1, EV_FINISH, 8'h7E, 16'd0);
    for (int i = 0; i < DEPTH; i++)
      add_row(OP_ARRIVE, 8'(8'h10 + i), 16'(2 + i), 16'd4, 0, EV_START, 8'h00, 16'd0);
    add_row(OP_ARRIVE, 8'hFF, 16'hFFFF, 16'hFFFF, 1, EV_REJECT, 8'hFF, 16'hFFFF);
    add_row(OP_TICK,   8'h00, 16'd0,     16'd0,     1, EV_STOP,   8'h81, 16'd298);

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      send_item(row.op, row.id, row.burst, row.arr);
      if (row.typed && (evs.size() == 0 || evs[0].kind != row.x_kind ||
                        evs[0].id != row.x_id || evs[0].rem != row.x_rem)) begin
        $error("directed row %0d: table says %s task %0d remaining %0d",
               i, row.x_kind.name(), row.x_id, row.x_rem);
        mism++;
      end
    end

    foreach (slice_plan[i]) begin
      set_slice(slice_plan[i]);
      run_phase(190);
    end

    set_slice(8'($urandom_range(1, 255)));
    run_phase(20);

    in_valid = 1'b0;
    while (pending_ev.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mism == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/rrs_pkg.sv
hdl/rrs_ctrl.sv
hdl/rrs_datapath.sv
hdl/round_robin_scheduler.sv
tb/testbench.sv
